// File: src/hmp2mid_pkg.sv
// ----------------------------------------------------------------------------
// hmp2mid_pkg
// types and constants for the hmp to midi track converter
// ----------------------------------------------------------------------------
package hmp2mid_pkg;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_CONVERTING = 2'd0,
    ST_FINISHED   = 2'd1,
    ST_MALFORMED  = 2'd2
  } track_status_t;

  localparam int OUT_COUNT_W = 24;

  localparam logic [7:0] BYTE_META      = 8'hFF;
  localparam logic [7:0] META_END_TRACK = 8'h2F;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;
  localparam logic [3:0] HI_PROGRAM     = 4'hC;
  localparam logic [3:0] HI_PRESSURE    = 4'hD;

endpackage

// File: src/hmp_to_midi_track_converter.sv
// ----------------------------------------------------------------------------
// hmp_to_midi_track_converter
// converts a stream of hmp track bytes into standard midi track bytes
// ----------------------------------------------------------------------------
// One hmp byte is taken per beat on the slave side and turns into a run of
// zero to MAX_DELTA_BYTES midi bytes on the master side; a byte that yields
// nothing still gives one empty beat with tuser low. The parser works on a
// byte in the cycle it is accepted and loads the run into an output register,
// and the next byte is taken in the same cycle as the last beat of that run
// leaves. While m_axis_tready is high, a byte is therefore accepted every cycle
// while each gives one beat, and a byte that closes a delta time of n groups,
// its own group included, gives n beats, sent one per cycle by the output
// serializer. tuser on the slave side restarts the parser for a new track.
module hmp_to_midi_track_converter
  import hmp2mid_pkg::*;
#(
  parameter int MAX_DELTA_BYTES = 4,
  parameter int COUNT_WIDTH     = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tuser,   // track_start
  input  logic        s_axis_tlast,   // track_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte, status, emitted_count, zero pad
  output logic        m_axis_tuser,   // has_byte
  output logic        m_axis_tlast    // run_last
);

  localparam int DCW = (MAX_DELTA_BYTES > 2) ? $clog2(MAX_DELTA_BYTES) : 1;
  localparam int NW  = $clog2(MAX_DELTA_BYTES + 1);
  localparam int GD  = MAX_DELTA_BYTES - 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // parser state
  phase_t                 phase, phase_next;
  logic [DCW-1:0]         delta_count, delta_count_next;
  logic [7:0]             running_status, running_status_next;
  logic [1:0]             data_left, data_left_next;
  logic [7:0]             meta_left, meta_left_next;
  logic                   meta_is_end, meta_is_end_next;
  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic [GD-1:0][6:0]     delta_groups;

  // run register
  logic                             run_valid;
  logic [MAX_DELTA_BYTES-1:0][7:0]  run_bytes;
  logic [NW-1:0]                    run_n;
  logic [DCW-1:0]                   run_idx;
  track_status_t                    run_status;
  logic [COUNT_WIDTH-1:0]           run_base;

  // parse results
  logic [MAX_DELTA_BYTES-1:0][7:0]  em_bytes;
  logic [NW-1:0]                    em_n;
  logic                             shift_en;
  track_status_t                    status_next;

  phase_t                 cur_phase;
  logic [DCW-1:0]         cur_dc;
  logic [7:0]             cur_rs;
  logic [1:0]             cur_dl;
  logic [7:0]             cur_ml;
  logic                   cur_end;
  logic [COUNT_WIDTH-1:0] cur_bc;
  logic [COUNT_WIDTH:0]   bc_sum;
  logic [7:0]             in_b;

  logic                   accept;
  logic                   beat_take;
  logic                   beat_last;
  logic [COUNT_WIDTH:0]   out_sum;
  logic [COUNT_WIDTH-1:0] out_count;
  logic [7:0]             out_byte;

  assign in_b = s_axis_tdata;

  always_comb begin
    cur_phase = s_axis_tuser ? PH_DELTA : phase;
    cur_dc    = s_axis_tuser ? '0 : delta_count;
    cur_rs    = s_axis_tuser ? '0 : running_status;
    cur_dl    = s_axis_tuser ? '0 : data_left;
    cur_ml    = s_axis_tuser ? '0 : meta_left;
    cur_end   = s_axis_tuser ? 1'b0 : meta_is_end;
    cur_bc    = s_axis_tuser ? '0 : byte_count;

    phase_next          = cur_phase;
    delta_count_next    = cur_dc;
    running_status_next = cur_rs;
    data_left_next      = cur_dl;
    meta_left_next      = cur_ml;
    meta_is_end_next    = cur_end;
    shift_en            = 1'b0;
    em_bytes            = '0;
    em_n                = '0;

    unique case (cur_phase)
      PH_DELTA: begin
        if (in_b[7]) begin
          em_bytes[0] = {cur_dc != '0, in_b[6:0]};
          for (int j = 1; j < MAX_DELTA_BYTES; j++) begin
            if (j <= int'(cur_dc)) begin
              em_bytes[j] = {j < int'(cur_dc), delta_groups[j-1]};
            end
          end
          em_n             = NW'(cur_dc) + NW'(1);
          delta_count_next = '0;
          phase_next       = PH_STATUS;
        end else if (cur_dc >= DCW'(MAX_DELTA_BYTES - 1)) begin
          phase_next = PH_ERROR;
        end else begin
          shift_en         = 1'b1;
          delta_count_next = cur_dc + DCW'(1);
        end
      end
      PH_STATUS: begin
        if (in_b == BYTE_META) begin
          em_bytes[0] = in_b;
          em_n        = NW'(1);
          phase_next  = PH_META_TYPE;
        end else if (!in_b[7] || in_b[7:4] == HI_SYSTEM) begin
          phase_next = PH_ERROR;
        end else begin
          if (in_b != cur_rs) begin
            em_bytes[0] = in_b;
            em_n        = NW'(1);
          end
          running_status_next = in_b;
          data_left_next = (in_b[7:4] == HI_PROGRAM || in_b[7:4] == HI_PRESSURE) ?
                           2'd1 : 2'd2;
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        em_bytes[0] = in_b;
        em_n        = NW'(1);
        if (cur_dl != '0) begin
          data_left_next = cur_dl - 2'd1;
        end
        if (data_left_next == '0) begin
          phase_next = PH_DELTA;
        end
      end
      PH_META_TYPE: begin
        em_bytes[0]      = in_b;
        em_n             = NW'(1);
        meta_is_end_next = (in_b == META_END_TRACK);
        phase_next       = PH_META_LEN;
      end
      PH_META_LEN: begin
        em_bytes[0]    = in_b;
        em_n           = NW'(1);
        meta_left_next = in_b;
        if (in_b == '0) begin
          phase_next = cur_end ? PH_DONE : PH_DELTA;
        end else begin
          phase_next = PH_META_DATA;
        end
      end
      PH_META_DATA: begin
        em_bytes[0] = in_b;
        em_n        = NW'(1);
        if (cur_ml != '0) begin
          meta_left_next = cur_ml - 8'd1;
        end
        if (meta_left_next == '0) begin
          phase_next = cur_end ? PH_DONE : PH_DELTA;
        end
      end
      PH_DONE, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (s_axis_tlast && phase_next != PH_DONE && phase_next != PH_ERROR) begin
      phase_next = (phase_next == PH_DELTA && delta_count_next == '0) ?
                   PH_DONE : PH_ERROR;
    end

    unique case (phase_next)
      PH_DONE:  status_next = ST_FINISHED;
      PH_ERROR: status_next = ST_MALFORMED;
      default:  status_next = ST_CONVERTING;
    endcase

    bc_sum          = {1'b0, cur_bc} + (COUNT_WIDTH + 1)'(em_n);
    byte_count_next = bc_sum[COUNT_WIDTH] ? COUNT_MAX : bc_sum[COUNT_WIDTH-1:0];
  end

  // output serializer
  assign beat_last = (run_n == '0) || (NW'(run_idx) == run_n - NW'(1));
  assign beat_take = run_valid && m_axis_tready;
  assign s_axis_tready = !run_valid || (beat_take && beat_last);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (run_n == '0) begin
      out_sum = {1'b0, run_base};
    end else begin
      out_sum = {1'b0, run_base} + (COUNT_WIDTH + 1)'(run_idx) + (COUNT_WIDTH + 1)'(1);
    end
    out_count = out_sum[COUNT_WIDTH] ? COUNT_MAX : out_sum[COUNT_WIDTH-1:0];
    out_byte  = (run_n == '0) ? 8'd0 : run_bytes[run_idx];
  end

  assign m_axis_tvalid = run_valid;
  assign m_axis_tuser  = (run_n != '0);
  assign m_axis_tlast  = beat_last;
  assign m_axis_tdata  = {6'd0, OUT_COUNT_W'(out_count), run_status, out_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      delta_count    <= '0;
      running_status <= '0;
      data_left      <= '0;
      meta_left      <= '0;
      meta_is_end    <= 1'b0;
      byte_count     <= '0;
      run_valid      <= 1'b0;
      run_idx        <= '0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        delta_count    <= delta_count_next;
        running_status <= running_status_next;
        data_left      <= data_left_next;
        meta_left      <= meta_left_next;
        meta_is_end    <= meta_is_end_next;
        byte_count     <= byte_count_next;
        run_valid      <= 1'b1;
        run_idx        <= '0;
      end else if (beat_take) begin
        if (beat_last) begin
          run_valid <= 1'b0;
        end else begin
          run_idx <= run_idx + DCW'(1);
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      run_bytes  <= em_bytes;
      run_n      <= em_n;
      run_status <= status_next;
      run_base   <= cur_bc;
      if (shift_en) begin
        delta_groups[0] <= in_b[6:0];
        for (int k = 1; k < GD; k++) begin
          delta_groups[k] <= delta_groups[k-1];
        end
      end
    end
  end

  // checks
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_n != '0 |-> NW'(run_idx) < run_n)
    else $error("run index past run length");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> run_n <= NW'(MAX_DELTA_BYTES))
    else $error("run longer than allowed");

  a_delta_depth: assert property (@(posedge clk) disable iff (rst)
    delta_count <= DCW'(MAX_DELTA_BYTES - 1))
    else $error("delta buffer overfilled");

  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> run_valid && run_idx == '0)
    else $error("accepted beat did not start a run");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !s_axis_tuser && (phase == PH_DONE || phase == PH_ERROR)
    |=> run_n == '0)
    else $error("bytes emitted after track end or error");

endmodule
